@@ design/dsca_pkg.sv @@
`timescale 1ns / 1ps
// shared mode codes, polynomials and control types for the crc sniffer
package dsca_pkg;

	localparam logic [2:0] MODE_CRC32   = 3'd0;
	localparam logic [2:0] MODE_CRC32R  = 3'd1;
	localparam logic [2:0] MODE_CRC16   = 3'd2;
	localparam logic [2:0] MODE_CRC16R  = 3'd3;
	localparam logic [2:0] MODE_PARITY  = 3'd4;
	localparam logic [2:0] MODE_SUM     = 3'd5;

	localparam logic [1:0] REG_MODE     = 2'd0;
	localparam logic [1:0] REG_REVERSE  = 2'd1;
	localparam logic [1:0] REG_INVERT   = 2'd2;

	localparam logic [1:0] SIZE_BYTE    = 2'd0;
	localparam logic [1:0] SIZE_HALF    = 2'd1;

	localparam logic       OP_FEED      = 1'b0;

	localparam logic [31:0] POLY_CRC32  = 32'h04C1_1DB7;
	localparam logic [31:0] POLY_CRC32R = 32'hEDB8_8320;
	localparam logic [31:0] POLY_CRC16  = 32'h0000_1021;
	localparam logic [31:0] POLY_CRC16R = 32'h0000_8408;
	localparam logic [15:0] MASK16      = 16'hFFFF;

	typedef struct packed {
		logic [2:0] mode;
		logic       out_reverse;
		logic       out_invert;
	} dsca_cfg_t;

endpackage

@@ design/dsca_byte_lane.sv @@
`timescale 1ns / 1ps
// one byte of crc update for the configured mode
module dsca_byte_lane (
	input  logic [2:0]  mode,
	input  logic [7:0]  data_byte,
	input  logic [31:0] acc_in,
	output logic [31:0] acc_out
);

	logic [31:0] acc;

	always_comb begin
		acc = acc_in;
		case (mode)
			dsca_pkg::MODE_CRC32: begin
				acc = acc ^ {data_byte, 24'h0};
				for (int b = 0; b < 8; b++) begin
					acc = acc[31] ? ((acc << 1) ^ dsca_pkg::POLY_CRC32) : (acc << 1);
				end
			end
			dsca_pkg::MODE_CRC32R: begin
				acc = acc ^ {24'h0, data_byte};
				for (int b = 0; b < 8; b++) begin
					acc = acc[0] ? ((acc >> 1) ^ dsca_pkg::POLY_CRC32R) : (acc >> 1);
				end
			end
			dsca_pkg::MODE_CRC16: begin
				acc = acc ^ {16'h0, data_byte, 8'h0};
				for (int b = 0; b < 8; b++) begin
					acc = acc[15] ? ((acc << 1) ^ dsca_pkg::POLY_CRC16) : (acc << 1);
				end
				acc = {16'h0, acc[15:0] & dsca_pkg::MASK16};
			end
			dsca_pkg::MODE_CRC16R: begin
				// upper half of a wide seed is dropped before each byte
				acc = {16'h0, acc[15:0] & dsca_pkg::MASK16} ^ {24'h0, data_byte};
				for (int b = 0; b < 8; b++) begin
					acc = acc[0] ? ((acc >> 1) ^ dsca_pkg::POLY_CRC16R) : (acc >> 1);
				end
			end
			default: begin
				acc = acc_in;
			end
		endcase
	end

	assign acc_out = acc;

endmodule

@@ design/dsca_next.sv @@
`timescale 1ns / 1ps
// next accumulator value from one transaction: seed load, crc lanes, parity or sum
module dsca_next (
	input  logic [2:0]  mode,
	input  logic        op,
	input  logic [31:0] data_value,
	input  logic [1:0]  elem_size,
	input  logic [31:0] acc,
	output logic [31:0] acc_next
);

	logic [31:0] lane_in  [4];
	logic [31:0] lane_out [4];

	genvar k;
	generate
		for (k = 0; k < 4; k++) begin : g_lane
			if (k == 0) begin : g_first
				assign lane_in[k] = acc;
			end else begin : g_chain
				assign lane_in[k] = lane_out[k-1];
			end
			dsca_byte_lane u_lane (
				.mode      (mode),
				.data_byte (data_value[8*k +: 8]),
				.acc_in    (lane_in[k]),
				.acc_out   (lane_out[k])
			);
		end
	endgenerate

	always_comb begin
		acc_next = acc;
		if (op != dsca_pkg::OP_FEED) begin
			acc_next = data_value;
		end else begin
			case (mode)
				dsca_pkg::MODE_CRC32,
				dsca_pkg::MODE_CRC32R,
				dsca_pkg::MODE_CRC16,
				dsca_pkg::MODE_CRC16R: begin
					// size code 3 counts as a four-byte element
					if (elem_size == dsca_pkg::SIZE_BYTE) begin
						acc_next = lane_out[0];
					end else if (elem_size == dsca_pkg::SIZE_HALF) begin
						acc_next = lane_out[1];
					end else begin
						acc_next = lane_out[3];
					end
				end
				dsca_pkg::MODE_PARITY: begin
					acc_next = acc ^ data_value;
				end
				default: begin
					// sum, and the unused codes behave as sum
					acc_next = acc + data_value;
				end
			endcase
		end
	end

endmodule

@@ design/dma_sniffer_crc_accumulator.sv @@
`timescale 1ns / 1ps
// top level of the dma sniffer crc / checksum accumulator
// The sniffer takes one transaction per clock while the output is not
// stalled, and returns one result per transaction: a transaction either
// loads a seed word or feeds an element of 1, 2 or 4 bytes (low byte
// first) through CRC-32, reflected CRC-32, CRC-16-CCITT, reflected CRC-16,
// XOR parity or a wrapping sum, and the result is the new accumulator,
// optionally bit-reversed and then inverted. An accepted transaction is
// held in the input register and its result in the output register; the
// full four-byte crc update lies combinationally between the input register
// and the accumulator. Configuration writes are always accepted and must
// only be made while no transaction is in flight.
module dma_sniffer_crc_accumulator (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [31:0] data_value,
	input  logic [1:0]  elem_size,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] sniff_value
);

	dsca_pkg::dsca_cfg_t cfg_q;

	logic        valid_s1;
	logic        op_s1;
	logic [31:0] data_s1;
	logic [1:0]  size_s1;

	logic [31:0] acc_q;
	logic [31:0] acc_next;
	logic [31:0] acc_rev;
	logic [31:0] readout;
	logic        out_valid_q;
	logic [31:0] sniff_q;
	logic        advance;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				dsca_pkg::REG_MODE:    cfg_q.mode        <= cfg_data[2:0];
				dsca_pkg::REG_REVERSE: cfg_q.out_reverse <= cfg_data[0];
				dsca_pkg::REG_INVERT:  cfg_q.out_invert  <= cfg_data[0];
				default:               cfg_q             <= cfg_q;
			endcase
		end
	end

	// stage 1 moves on whenever the result register is free or being drained
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1   <= op;
			data_s1 <= data_value;
			size_s1 <= elem_size;
		end
	end

	dsca_next u_next (
		.mode       (cfg_q.mode),
		.op         (op_s1),
		.data_value (data_s1),
		.elem_size  (size_s1),
		.acc        (acc_q),
		.acc_next   (acc_next)
	);

	always_comb begin
		for (int i = 0; i < 32; i++) begin
			acc_rev[i] = acc_next[31-i];
		end
	end

	assign readout = (cfg_q.out_reverse ? acc_rev : acc_next) ^ {32{cfg_q.out_invert}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				acc_q <= acc_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			sniff_q <= readout;
		end
	end

	assign out_valid   = out_valid_q;
	assign sniff_value = sniff_q;

endmodule

@@ design/dsca_checker.sv @@
`timescale 1ns / 1ps
// port-level checks for the crc sniffer and their binding to the top level
module dsca_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_ready,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] sniff_value
);

	// a stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sniff_value))
		else $error("result changed while stalled");

	// an empty result register never blocks the input side
	a_in_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// an accepted transaction reaches the output once out_ready is high after its acceptance
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) ##1 out_ready |=> out_valid)
		else $error("transaction result missing");

	// configuration is never back-pressured
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("config port not ready");

endmodule

bind dma_sniffer_crc_accumulator dsca_checker u_dsca_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cfg_ready   (cfg_ready),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.sniff_value (sniff_value)
);

@@ tb/dma_sniffer_crc_accumulator_tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the dma sniffer crc / checksum accumulator
module dma_sniffer_crc_accumulator_tb;

	localparam logic       OP_SEED     = 1'b1;
	localparam logic [1:0] SIZE_WORD   = 2'd2;
	localparam logic [1:0] SIZE_OVER   = 2'd3;
	localparam logic [2:0] MODE_SPARE6 = 3'd6;
	localparam logic [2:0] MODE_SPARE7 = 3'd7;
	localparam int PIPE_LATENCY   = 4;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int NUM_PHASES     = 20;

	class sniff_value_scoreboard;
		logic [31:0] accumulator;
		logic [2:0]  mode;
		logic        rev;
		logic        inv;
		logic [31:0] expected_sniff_q[$];
		int          errors;
		int          checked;
		int          reg_writes;
		int          seeds;
		int          feeds_by_mode[8];

		function new();
			accumulator = '0;
			mode = dsca_pkg::MODE_CRC32;
			rev = 1'b0;
			inv = 1'b0;
			errors = 0;
			checked = 0;
			reg_writes = 0;
			seeds = 0;
			foreach (feeds_by_mode[i]) feeds_by_mode[i] = 0;
		endfunction

		function int pending();
			return expected_sniff_q.size();
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $realtime, msg);
			errors++;
		endtask

		function void set_reg(logic [1:0] idx, logic [31:0] d);
			reg_writes++;
			case (idx)
				dsca_pkg::REG_MODE:    mode = d[2:0];
				dsca_pkg::REG_REVERSE: rev = d[0];
				dsca_pkg::REG_INVERT:  inv = d[0];
				default: ;
			endcase
		endfunction

		function logic [31:0] bit_reverse(logic [31:0] v);
			logic [31:0] r;
			for (int i = 0; i < 32; i++) r[i] = v[31 - i];
			return r;
		endfunction

		// msb-first byte step; the 16-bit form keeps stray upper bits until the final mask
		function logic [31:0] msb_byte_step(logic [31:0] a, logic [7:0] b, logic [31:0] poly,
				bit wide);
			logic [31:0] r;
			r = wide ? (a ^ {b, 24'h0}) : (a ^ {16'h0, b, 8'h0});
			for (int k = 0; k < 8; k++) begin
				if (wide ? r[31] : r[15]) r = (r << 1) ^ poly;
				else r = r << 1;
			end
			return wide ? r : (r & {16'h0, dsca_pkg::MASK16});
		endfunction

		function logic [31:0] lsb_byte_step(logic [31:0] a, logic [7:0] b, logic [31:0] poly);
			logic [31:0] r;
			r = a ^ {24'h0, b};
			for (int k = 0; k < 8; k++) begin
				if (r[0]) r = (r >> 1) ^ poly;
				else r = r >> 1;
			end
			return r;
		endfunction

		function void note_transfer(logic op_i, logic [31:0] d, logic [1:0] sz);
			int          nbytes;
			logic [7:0]  b;
			logic [31:0] r;
			nbytes = (sz == dsca_pkg::SIZE_BYTE) ? 1 : ((sz == dsca_pkg::SIZE_HALF) ? 2 : 4);
			if (op_i != dsca_pkg::OP_FEED) begin
				accumulator = d;
				seeds++;
			end else begin
				feeds_by_mode[mode]++;
				case (mode)
					dsca_pkg::MODE_CRC32, dsca_pkg::MODE_CRC32R,
					dsca_pkg::MODE_CRC16, dsca_pkg::MODE_CRC16R: begin
						for (int i = 0; i < nbytes; i++) begin
							b = d[8 * i +: 8];
							case (mode)
								dsca_pkg::MODE_CRC32:
									accumulator = msb_byte_step(accumulator, b,
										dsca_pkg::POLY_CRC32, 1'b1);
								dsca_pkg::MODE_CRC32R:
									accumulator = lsb_byte_step(accumulator, b,
										dsca_pkg::POLY_CRC32R);
								dsca_pkg::MODE_CRC16:
									accumulator = msb_byte_step(accumulator, b,
										dsca_pkg::POLY_CRC16, 1'b0);
								default:
									accumulator = lsb_byte_step(
										accumulator & {16'h0, dsca_pkg::MASK16}, b,
										dsca_pkg::POLY_CRC16R);
							endcase
						end
					end
					dsca_pkg::MODE_PARITY: accumulator = accumulator ^ d;
					// spare mode codes fall back to the sum
					default:     accumulator = accumulator + d;
				endcase
			end
			r = accumulator;
			if (rev) r = bit_reverse(r);
			if (inv) r = ~r;
			expected_sniff_q.push_back(r);
		endfunction

		task check_sniff_value(logic [31:0] v);
			logic [31:0] want;
			if (expected_sniff_q.size() == 0) begin
				report($sformatf("result %h with no transaction outstanding", v));
				return;
			end
			want = expected_sniff_q.pop_front();
			checked++;
			if (v !== want) report($sformatf("sniff_value %h, expected %h", v, want));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = dsca_pkg::REG_MODE;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        op = dsca_pkg::OP_FEED;
	logic [31:0] data_value = '0;
	logic [1:0]  elem_size = dsca_pkg::SIZE_BYTE;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] sniff_value;

	int in_gap_max = 3;
	int out_stall_max = 3;

	sniff_value_scoreboard sb = new();

	dma_sniffer_crc_accumulator i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.data_value  (data_value),
		.elem_size   (elem_size),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.sniff_value (sniff_value)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
			if (in_valid && in_ready) sb.note_transfer(op, data_value, elem_size);
			if (out_valid && out_ready) sb.check_sniff_value(sniff_value);
		end
	end

	initial begin : result_sink
		int stall;
		forever begin
			stall = $urandom_range(0, out_stall_max);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("dma_sniffer_crc_accumulator_tb NOT OK");
		$finish;
	end

	task automatic send_item(logic op_i, logic [31:0] d, logic [1:0] sz);
		int gap;
		gap = $urandom_range(0, in_gap_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		op         <= op_i;
		data_value <= d;
		elem_size  <= sz;
		do @(posedge clk); while (!in_ready);
	endtask

	// stop sending and let every outstanding transaction come back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (PIPE_LATENCY) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		logic [31:0] junk;
		// unused upper bits get random content half the time
		junk = $urandom_range(0, 1) ? ($urandom & ~32'h7) : 32'h0;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= junk | val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_config(logic [2:0] mode, logic rev, logic inv);
		write_reg(dsca_pkg::REG_MODE, {29'h0, mode});
		write_reg(dsca_pkg::REG_REVERSE, {31'h0, rev});
		write_reg(dsca_pkg::REG_INVERT, {31'h0, inv});
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] pick_data(logic [1:0] sz);
		logic [31:0] v;
		v = $urandom;
		case ($urandom_range(0, 7))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2, 3: begin
				if (sz == dsca_pkg::SIZE_BYTE) return v & 32'h0000_00FF;
				if (sz == dsca_pkg::SIZE_HALF) return v & 32'h0000_FFFF;
				return v;
			end
			default: return v;
		endcase
	endfunction

	initial begin : stimulus
		int          n;
		logic [2:0]  mode;
		logic        rev;
		logic        inv;
		logic        op_pick;
		logic [1:0]  sz;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: crc32 with plain readout
		send_item(dsca_pkg::OP_FEED, 32'h0000_0000, dsca_pkg::SIZE_BYTE);
		send_item(dsca_pkg::OP_FEED, 32'h0000_00FF, dsca_pkg::SIZE_BYTE);
		send_item(dsca_pkg::OP_FEED, 32'h0000_FFFF, dsca_pkg::SIZE_HALF);
		send_item(dsca_pkg::OP_FEED, 32'hFFFF_FFFF, SIZE_WORD);
		send_item(dsca_pkg::OP_FEED, 32'h1234_5678, SIZE_OVER);
		send_item(OP_SEED, 32'hFFFF_FFFF, dsca_pkg::SIZE_BYTE);
		send_item(dsca_pkg::OP_FEED, 32'hA5A5_A5A5, dsca_pkg::SIZE_BYTE);
		drain();
		set_config(dsca_pkg::MODE_CRC32R, 1'b1, 1'b0);
		send_item(OP_SEED, 32'hFFFF_FFFF, SIZE_OVER);
		send_item(dsca_pkg::OP_FEED, 32'h0000_0031, dsca_pkg::SIZE_BYTE);
		send_item(dsca_pkg::OP_FEED, 32'hFFFF_FFFF, SIZE_WORD);
		drain();
		// wide seeds in the 16-bit crc modes
		set_config(dsca_pkg::MODE_CRC16, 1'b0, 1'b1);
		send_item(OP_SEED, 32'hDEAD_BEEF, dsca_pkg::SIZE_BYTE);
		send_item(dsca_pkg::OP_FEED, 32'h0000_FFFF, dsca_pkg::SIZE_HALF);
		send_item(dsca_pkg::OP_FEED, 32'h8000_0000, SIZE_OVER);
		drain();
		set_config(dsca_pkg::MODE_CRC16R, 1'b1, 1'b1);
		send_item(OP_SEED, 32'hFFFF_FFFF, dsca_pkg::SIZE_HALF);
		send_item(dsca_pkg::OP_FEED, 32'h0000_0000, dsca_pkg::SIZE_BYTE);
		send_item(dsca_pkg::OP_FEED, 32'h0000_1234, dsca_pkg::SIZE_HALF);
		drain();
		// parity and sum take the whole word regardless of size
		set_config(dsca_pkg::MODE_PARITY, 1'b0, 1'b0);
		send_item(dsca_pkg::OP_FEED, 32'hFFFF_0001, dsca_pkg::SIZE_BYTE);
		send_item(dsca_pkg::OP_FEED, 32'h8000_0000, dsca_pkg::SIZE_HALF);
		drain();
		set_config(dsca_pkg::MODE_SUM, 1'b0, 1'b1);
		send_item(dsca_pkg::OP_FEED, 32'hFFFF_FFFF, dsca_pkg::SIZE_BYTE);
		send_item(dsca_pkg::OP_FEED, 32'h0000_0001, dsca_pkg::SIZE_BYTE);
		drain();
		set_config(MODE_SPARE6, 1'b1, 1'b0);
		send_item(dsca_pkg::OP_FEED, 32'h8000_0000, SIZE_WORD);
		drain();
		set_config(MODE_SPARE7, 1'b0, 1'b0);
		send_item(dsca_pkg::OP_FEED, 32'h8000_0000, dsca_pkg::SIZE_HALF);

		for (int p = 0; p < NUM_PHASES; p++) begin
			drain();
			// first phases walk every mode code, the rest are random
			if (p < 8) begin
				mode = p[2:0];
				rev  = p[0];
				inv  = p[1];
			end else begin
				mode = 3'($urandom_range(0, 7));
				rev  = 1'($urandom_range(0, 1));
				inv  = 1'($urandom_range(0, 1));
			end
			set_config(mode, rev, inv);
			in_gap_max    = $urandom_range(0, 1) ? 3 : 0;
			out_stall_max = $urandom_range(0, 1) ? 3 : 0;
			n = $urandom_range(40, 95);
			for (int k = 0; k < n; k++) begin
				op_pick = ($urandom_range(0, 7) == 0) ? OP_SEED : dsca_pkg::OP_FEED;
				sz = 2'($urandom_range(0, 3));
				send_item(op_pick, pick_data(sz), sz);
				if ((k == n / 2 && p % 5 == 2) || $urandom_range(0, 99) == 0) drain();
			end
		end
		drain();

		$display("covered %0d seed loads; feeds crc32 %0d, crc32r %0d, crc16 %0d, crc16r %0d,",
			sb.seeds, sb.feeds_by_mode[0], sb.feeds_by_mode[1], sb.feeds_by_mode[2],
			sb.feeds_by_mode[3]);
		$display("parity %0d, sum %0d, spare %0d; %0d results over %0d register writes",
			sb.feeds_by_mode[4], sb.feeds_by_mode[5], sb.feeds_by_mode[6] + sb.feeds_by_mode[7],
			sb.checked, sb.reg_writes);
		if (sb.errors == 0)
			$display("dma_sniffer_crc_accumulator_tb OK");
		else
			$display("dma_sniffer_crc_accumulator_tb NOT OK");
		$finish;
	end

endmodule

@@ filelist.f @@
design/dsca_pkg.sv
design/dsca_byte_lane.sv
design/dsca_next.sv
design/dma_sniffer_crc_accumulator.sv
design/dsca_checker.sv
tb/dma_sniffer_crc_accumulator_tb.sv
